FILE: hdl/bcu_pkg.sv
// Shared types, constants and command codes of the binomial coefficient unit.
package bcu_pkg;

    // Datapath word width and fixed port width
    localparam int WORD_BITS  = 64;
    localparam int FIELD_BITS = 64;
    localparam int CNT_BITS   = $clog2(WORD_BITS + 1);

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_LOOP,
        S_CMP1,
        S_DIVD,
        S_STEP,
        S_EU_TEST,
        S_NG,
        S_DG,
        S_EU2,
        S_RG,
        S_DRG,
        S_CHK2,
        S_CMP2,
        S_DIVDR,
        S_WAIT,
        S_FIN
    } t_state;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MIRROR,
        OP_DIV_TOPN,
        OP_DIV_TOPNR,
        OP_DIV_RD,
        OP_DIV_RDR,
        OP_DIV_NG,
        OP_DIV_DG,
        OP_DIV_RG,
        OP_DIV_DRG,
        OP_EU_MOD,
        OP_MUL_RN,
        OP_MUL_RNR,
        OP_STEP,
        OP_EU_ND,
        OP_EU_RDR,
        OP_RES
    } t_op;

    // Result selection
    typedef enum logic [2:0] {
        RES_ONE,
        RES_N,
        RES_ZERO,
        RES_R,
        RES_OVF
    } t_res;

    // Write-back destination of the divider
    typedef enum logic [2:0] {
        DST_Q,
        DST_R,
        DST_NR,
        DST_DR,
        DST_B
    } t_dst;

    typedef struct packed {
        t_op  op;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic k_zero;
        logic k_one;
        logic k_ge_n;
        logic k_eq_n;
        logic k_gt_half;
        logic d_gt_k;
        logic r_ge_q;
        logic b_zero;
        logic nr_dr_zero;
        logic unit_done;
        logic out_free;
    } t_status;

endpackage

FILE: hdl/bcu_div.sv
// Restoring divider, one quotient bit per cycle.
module bcu_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bcu_pkg::WORD_BITS-1:0] i_dividend,
    input  logic [bcu_pkg::WORD_BITS-1:0] i_divisor,
    output logic [bcu_pkg::WORD_BITS-1:0] o_quotient,
    output logic [bcu_pkg::WORD_BITS-1:0] o_remainder,
    output logic                          o_done
);
    logic [bcu_pkg::WORD_BITS-1:0] r_rem;
    logic [bcu_pkg::WORD_BITS-1:0] r_quo;
    logic [bcu_pkg::WORD_BITS-1:0] r_dvs;
    logic [bcu_pkg::CNT_BITS-1:0]  r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [bcu_pkg::WORD_BITS:0]   shifted;
    logic [bcu_pkg::WORD_BITS:0]   diff;

    // Trial subtraction
    assign shifted = {r_rem, r_quo[bcu_pkg::WORD_BITS-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= bcu_pkg::CNT_BITS'(bcu_pkg::WORD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == bcu_pkg::CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[bcu_pkg::WORD_BITS]) begin
                r_rem <= diff[bcu_pkg::WORD_BITS-1:0];
                r_quo <= {r_quo[bcu_pkg::WORD_BITS-2:0], 1'b1};
            end else begin
                r_rem <= shifted[bcu_pkg::WORD_BITS-1:0];
                r_quo <= {r_quo[bcu_pkg::WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;
endmodule

FILE: hdl/bcu_mul.sv
// Shift-and-add multiplier, low word of the product, one bit per cycle.
module bcu_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bcu_pkg::WORD_BITS-1:0] i_a,
    input  logic [bcu_pkg::WORD_BITS-1:0] i_b,
    output logic [bcu_pkg::WORD_BITS-1:0] o_product,
    output logic                          o_done
);
    logic [bcu_pkg::WORD_BITS-1:0] r_acc;
    logic [bcu_pkg::WORD_BITS-1:0] r_mc;
    logic [bcu_pkg::WORD_BITS-1:0] r_mp;
    logic [bcu_pkg::CNT_BITS-1:0]  r_cnt;
    logic                          r_busy;
    logic                          r_done;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= bcu_pkg::CNT_BITS'(bcu_pkg::WORD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == bcu_pkg::CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Accumulate shifted multiplicand
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mc  <= i_a;
            r_mp  <= i_b;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= r_mc << 1;
            r_mp <= r_mp >> 1;
        end
    end

    assign o_product = r_acc;
    assign o_done    = r_done;
endmodule

FILE: hdl/bcu_dp.sv
// Datapath: working registers, shared divider and multiplier, output register.
module bcu_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bcu_pkg::t_cmd                  i_cmd,
    output bcu_pkg::t_status               o_status,
    input  logic [bcu_pkg::FIELD_BITS-1:0] i_set_size,
    input  logic [bcu_pkg::FIELD_BITS-1:0] i_choose_count,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bcu_pkg::FIELD_BITS-1:0] o_coefficient,
    output logic                           o_overflowed
);
    localparam logic [bcu_pkg::WORD_BITS-1:0] TOP = '1;

    logic [bcu_pkg::WORD_BITS-1:0] r_n, r_k, r_d, r_r, r_q, r_a, r_b, r_nr, r_dr;
    logic [bcu_pkg::WORD_BITS-1:0] r_coef;
    logic                          r_ovf;
    logic                          r_oval;
    bcu_pkg::t_dst                 r_dst;
    bcu_pkg::t_dst                 n_dst;
    logic [bcu_pkg::WORD_BITS-1:0] g;
    logic [bcu_pkg::WORD_BITS-1:0] div_x, div_y, quo, rem, prod, mul_b;
    logic                          div_start, div_done, mul_start, mul_done;

    // Gcd result, never zero
    assign g = (r_a == '0) ? bcu_pkg::WORD_BITS'(1) : r_a;

    // Divider operand selection
    always_comb begin
        div_start = 1'b1;
        div_x     = r_r;
        div_y     = r_d;
        n_dst     = bcu_pkg::DST_R;
        unique case (i_cmd.op)
            bcu_pkg::OP_DIV_TOPN:  begin div_x = TOP; div_y = r_n;  n_dst = bcu_pkg::DST_Q;  end
            bcu_pkg::OP_DIV_TOPNR: begin div_x = TOP; div_y = r_nr; n_dst = bcu_pkg::DST_Q;  end
            bcu_pkg::OP_DIV_RD:    begin div_x = r_r; div_y = r_d;  n_dst = bcu_pkg::DST_R;  end
            bcu_pkg::OP_DIV_RDR:   begin div_x = r_r; div_y = r_dr; n_dst = bcu_pkg::DST_R;  end
            bcu_pkg::OP_DIV_NG:    begin div_x = r_n; div_y = g;    n_dst = bcu_pkg::DST_NR; end
            bcu_pkg::OP_DIV_DG:    begin div_x = r_d; div_y = g;    n_dst = bcu_pkg::DST_DR; end
            bcu_pkg::OP_DIV_RG:    begin div_x = r_r; div_y = g;    n_dst = bcu_pkg::DST_R;  end
            bcu_pkg::OP_DIV_DRG:   begin div_x = r_dr; div_y = g;   n_dst = bcu_pkg::DST_DR; end
            bcu_pkg::OP_EU_MOD:    begin div_x = r_a; div_y = r_b;  n_dst = bcu_pkg::DST_B;  end
            default:               div_start = 1'b0;
        endcase
    end

    // Multiplier start and operand
    assign mul_start = (i_cmd.op == bcu_pkg::OP_MUL_RN) || (i_cmd.op == bcu_pkg::OP_MUL_RNR);
    assign mul_b     = (i_cmd.op == bcu_pkg::OP_MUL_RNR) ? r_nr : r_n;

    bcu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_x),
        .i_divisor  (div_y),
        .o_quotient (quo),
        .o_remainder(rem),
        .o_done     (div_done)
    );

    bcu_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (r_r),
        .i_b      (mul_b),
        .o_product(prod),
        .o_done   (mul_done)
    );

    // Working registers
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_dst <= n_dst;
        end
        if (div_done) begin
            unique case (r_dst)
                bcu_pkg::DST_Q:  r_q  <= quo;
                bcu_pkg::DST_R:  r_r  <= quo;
                bcu_pkg::DST_NR: r_nr <= quo;
                bcu_pkg::DST_DR: r_dr <= quo;
                bcu_pkg::DST_B:  begin r_a <= r_b; r_b <= rem; end
                default:         r_q  <= quo;
            endcase
        end
        if (mul_done) begin
            r_r <= prod;
        end
        unique case (i_cmd.op)
            bcu_pkg::OP_LOAD: begin
                r_n <= i_set_size[bcu_pkg::WORD_BITS-1:0];
                r_k <= i_choose_count[bcu_pkg::WORD_BITS-1:0];
                r_r <= bcu_pkg::WORD_BITS'(1);
                r_d <= bcu_pkg::WORD_BITS'(1);
            end
            bcu_pkg::OP_MIRROR: r_k <= r_n - r_k;
            bcu_pkg::OP_STEP: begin
                r_n <= r_n - 1'b1;
                r_d <= r_d + 1'b1;
            end
            bcu_pkg::OP_EU_ND: begin
                r_a <= (r_d < r_n) ? r_d : r_n;
                r_b <= (r_d < r_n) ? r_n : r_d;
            end
            bcu_pkg::OP_EU_RDR: begin
                r_a <= (r_dr < r_r) ? r_dr : r_r;
                r_b <= (r_dr < r_r) ? r_r : r_dr;
            end
            default: ;
        endcase
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bcu_pkg::OP_RES) begin
            r_ovf <= (i_cmd.res == bcu_pkg::RES_OVF);
            unique case (i_cmd.res)
                bcu_pkg::RES_ONE:  r_coef <= bcu_pkg::WORD_BITS'(1);
                bcu_pkg::RES_N:    r_coef <= r_n;
                bcu_pkg::RES_ZERO: r_coef <= '0;
                bcu_pkg::RES_R:    r_coef <= r_r;
                bcu_pkg::RES_OVF:  r_coef <= '0;
                default:           r_coef <= '0;
            endcase
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_cmd.op == bcu_pkg::OP_RES) begin
            r_oval <= 1'b1;
        end else if (i_out_ready) begin
            r_oval <= 1'b0;
        end
    end

    // Status to controller
    always_comb begin
        o_status.k_zero     = (r_k == '0);
        o_status.k_one      = (r_k == bcu_pkg::WORD_BITS'(1));
        o_status.k_ge_n     = (r_k >= r_n);
        o_status.k_eq_n     = (r_k == r_n);
        o_status.k_gt_half  = (r_k > (r_n >> 1));
        o_status.d_gt_k     = (r_d > r_k);
        o_status.r_ge_q     = (r_r >= r_q);
        o_status.b_zero     = (r_b == '0);
        o_status.nr_dr_zero = (r_nr == '0) || (r_dr == '0);
        o_status.unit_done  = div_done || mul_done;
        o_status.out_free   = !r_oval || i_out_ready;
    end

    assign o_out_valid   = r_oval;
    assign o_coefficient = bcu_pkg::FIELD_BITS'(r_coef);
    assign o_overflowed  = r_ovf;
endmodule

FILE: hdl/bcu_ctrl.sv
// Controller state machine sequencing the product loop and gcd reduction.
module bcu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bcu_pkg::t_status i_status,
    output bcu_pkg::t_cmd    o_cmd
);
    bcu_pkg::t_state r_state, n_state, r_ret, n_ret;
    bcu_pkg::t_res   r_res, n_res;
    logic            r_pass, n_pass;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcu_pkg::S_IDLE;
            r_ret   <= bcu_pkg::S_IDLE;
            r_res   <= bcu_pkg::RES_ZERO;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_res   <= n_res;
            r_pass  <= n_pass;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_res   = r_res;
        n_pass  = r_pass;
        unique case (r_state)
            bcu_pkg::S_IDLE: if (i_in_valid) n_state = bcu_pkg::S_CHECK;
            bcu_pkg::S_CHECK: begin
                priority if (i_status.k_zero) begin
                    n_res = bcu_pkg::RES_ONE; n_state = bcu_pkg::S_FIN;
                end else if (i_status.k_one) begin
                    n_res = bcu_pkg::RES_N; n_state = bcu_pkg::S_FIN;
                end else if (i_status.k_ge_n) begin
                    n_res = i_status.k_eq_n ? bcu_pkg::RES_ONE : bcu_pkg::RES_ZERO;
                    n_state = bcu_pkg::S_FIN;
                end else begin
                    n_state = bcu_pkg::S_LOOP;
                end
            end
            bcu_pkg::S_LOOP: begin
                if (i_status.d_gt_k) begin
                    n_res = bcu_pkg::RES_R; n_state = bcu_pkg::S_FIN;
                end else begin
                    n_ret = bcu_pkg::S_CMP1; n_state = bcu_pkg::S_WAIT;
                end
            end
            bcu_pkg::S_CMP1: begin
                if (i_status.r_ge_q) begin
                    n_pass = 1'b0; n_state = bcu_pkg::S_EU_TEST;
                end else begin
                    n_ret = bcu_pkg::S_DIVD; n_state = bcu_pkg::S_WAIT;
                end
            end
            bcu_pkg::S_DIVD: begin n_ret = bcu_pkg::S_STEP; n_state = bcu_pkg::S_WAIT; end
            bcu_pkg::S_STEP: n_state = bcu_pkg::S_LOOP;
            bcu_pkg::S_EU_TEST: begin
                if (i_status.b_zero) begin
                    n_state = r_pass ? bcu_pkg::S_RG : bcu_pkg::S_NG;
                end else begin
                    n_ret = bcu_pkg::S_EU_TEST; n_state = bcu_pkg::S_WAIT;
                end
            end
            bcu_pkg::S_NG:  begin n_ret = bcu_pkg::S_DG;  n_state = bcu_pkg::S_WAIT; end
            bcu_pkg::S_DG:  begin n_ret = bcu_pkg::S_EU2; n_state = bcu_pkg::S_WAIT; end
            bcu_pkg::S_EU2: begin n_pass = 1'b1; n_state = bcu_pkg::S_EU_TEST; end
            bcu_pkg::S_RG:  begin n_ret = bcu_pkg::S_DRG;  n_state = bcu_pkg::S_WAIT; end
            bcu_pkg::S_DRG: begin n_ret = bcu_pkg::S_CHK2; n_state = bcu_pkg::S_WAIT; end
            bcu_pkg::S_CHK2: begin
                if (i_status.nr_dr_zero) begin
                    n_res = bcu_pkg::RES_OVF; n_state = bcu_pkg::S_FIN;
                end else begin
                    n_ret = bcu_pkg::S_CMP2; n_state = bcu_pkg::S_WAIT;
                end
            end
            bcu_pkg::S_CMP2: begin
                if (i_status.r_ge_q) begin
                    n_res = bcu_pkg::RES_OVF; n_state = bcu_pkg::S_FIN;
                end else begin
                    n_ret = bcu_pkg::S_DIVDR; n_state = bcu_pkg::S_WAIT;
                end
            end
            bcu_pkg::S_DIVDR: begin n_ret = bcu_pkg::S_STEP; n_state = bcu_pkg::S_WAIT; end
            bcu_pkg::S_WAIT: if (i_status.unit_done) n_state = r_ret;
            bcu_pkg::S_FIN:  if (i_status.out_free) n_state = bcu_pkg::S_IDLE;
            default:         n_state = bcu_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd.op   = bcu_pkg::OP_NONE;
        o_cmd.res  = r_res;
        o_in_ready = 1'b0;
        unique case (r_state)
            bcu_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = bcu_pkg::OP_LOAD;
            end
            bcu_pkg::S_CHECK: begin
                if (!i_status.k_zero && !i_status.k_one && !i_status.k_ge_n
                    && i_status.k_gt_half) begin
                    o_cmd.op = bcu_pkg::OP_MIRROR;
                end
            end
            bcu_pkg::S_LOOP:  if (!i_status.d_gt_k) o_cmd.op = bcu_pkg::OP_DIV_TOPN;
            bcu_pkg::S_CMP1: begin
                o_cmd.op = i_status.r_ge_q ? bcu_pkg::OP_EU_ND : bcu_pkg::OP_MUL_RN;
            end
            bcu_pkg::S_DIVD:    o_cmd.op = bcu_pkg::OP_DIV_RD;
            bcu_pkg::S_STEP:    o_cmd.op = bcu_pkg::OP_STEP;
            bcu_pkg::S_EU_TEST: if (!i_status.b_zero) o_cmd.op = bcu_pkg::OP_EU_MOD;
            bcu_pkg::S_NG:      o_cmd.op = bcu_pkg::OP_DIV_NG;
            bcu_pkg::S_DG:      o_cmd.op = bcu_pkg::OP_DIV_DG;
            bcu_pkg::S_EU2:     o_cmd.op = bcu_pkg::OP_EU_RDR;
            bcu_pkg::S_RG:      o_cmd.op = bcu_pkg::OP_DIV_RG;
            bcu_pkg::S_DRG:     o_cmd.op = bcu_pkg::OP_DIV_DRG;
            bcu_pkg::S_CHK2:    if (!i_status.nr_dr_zero) o_cmd.op = bcu_pkg::OP_DIV_TOPNR;
            bcu_pkg::S_CMP2:    if (!i_status.r_ge_q) o_cmd.op = bcu_pkg::OP_MUL_RNR;
            bcu_pkg::S_DIVDR:   o_cmd.op = bcu_pkg::OP_DIV_RDR;
            bcu_pkg::S_WAIT:    o_cmd.op = bcu_pkg::OP_NONE;
            bcu_pkg::S_FIN:     if (i_status.out_free) o_cmd.op = bcu_pkg::OP_RES;
            default:            o_cmd.op = bcu_pkg::OP_NONE;
        endcase
    end
endmodule

FILE: hdl/binomial_coefficient_unit.sv
// Top level of the binomial coefficient unit.
// Input channel: i_in_valid / o_in_ready carry a request of set size n and
// choose count k. Output channel: o_out_valid / i_out_ready carry C(n,k) and
// an overflow flag; on overflow the coefficient reads 0.
// One request is worked on at a time. Trivial cases (k of 0 or 1, k not below
// n) go from the check state straight to the finish state. Otherwise each loop step
// costs one divide for the overflow bound, one multiply and one divide, each
// run on the shared bit-serial divider and multiplier and written back when
// done; a step that needs gcd reduction adds one
// divide per Euclid iteration plus five more divides. Latency is set by the
// number of steps, at most k and never more than 34 before the value fills
// the word.
// The result sits in an output register: once written, the unit takes the
// next request while the result waits. If the receiver stalls, a finished
// result is held until the register is free.
// Reset (synchronous, active low) returns to idle and drops o_out_valid.
module binomial_coefficient_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bcu_pkg::FIELD_BITS-1:0] i_set_size,
    input  logic [bcu_pkg::FIELD_BITS-1:0] i_choose_count,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bcu_pkg::FIELD_BITS-1:0] o_coefficient,
    output logic                           o_overflowed
);
    bcu_pkg::t_cmd    cmd;
    bcu_pkg::t_status status;

    bcu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    bcu_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_set_size    (i_set_size),
        .i_choose_count(i_choose_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_coefficient (o_coefficient),
        .o_overflowed  (o_overflowed)
    );
endmodule

FILE: hdl/bcu_checker.sv
// Port-level checker for the binomial coefficient unit, with its bind.
module bcu_port_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [bcu_pkg::FIELD_BITS-1:0] o_coefficient,
    input logic                           o_overflowed
);
    // A waiting result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Overflow always reports a zero coefficient
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflowed |-> o_coefficient == '0)
        else $error("overflow with non-zero coefficient");

    // Reset clears the output valid
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("valid after reset");

    // Busy after a request is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");

    // No result appears the cycle after a request is taken
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result too early");
endmodule

bind binomial_coefficient_unit bcu_port_checker u_bcu_port_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_coefficient(o_coefficient),
    .o_overflowed (o_overflowed)
);

FILE: tb/sv/bcu_checker.sv
// Checker of the binomial coefficient unit: predicts each request's result and compares.
`timescale 1ns / 100ps
module bcu_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_set_size,
    input  logic [63:0] i_choose_count,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_coefficient,
    input  logic        i_overflowed,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_ovf_seen
);
    localparam logic [63:0] TOP = (bcu_pkg::WORD_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                  : ((64'd1 << bcu_pkg::WORD_BITS) - 64'd1);

    typedef struct {
        logic [63:0] coef;
        logic        ovf;
    } t_binom;

    t_binom binom_q[$];

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        if (b < a) begin
            t = a;
            a = b;
            b = t;
        end
        while (b != 0) begin
            t = b;
            b = a % b;
            a = t;
        end
        return a;
    endfunction

    // Multiplicative scheme with gcd reduction near the top of the word
    function automatic t_binom binom_of(logic [63:0] n, logic [63:0] k);
        t_binom      res;
        logic [63:0] r, d, g, nr, dr;
        n = n & TOP;
        k = k & TOP;
        res.coef = 0;
        res.ovf  = 0;
        r = 1;
        if (k == 0) begin
            res.coef = 1;
            return res;
        end
        if (k == 1) begin
            res.coef = n;
            return res;
        end
        if (k >= n) begin
            res.coef = (k == n) ? 64'd1 : 64'd0;
            return res;
        end
        if (k > n / 2) k = n - k;
        for (d = 1; d <= k; d++) begin
            if (r >= TOP / n) begin
                g = gcd64(n, d);
                if (g == 0) g = 1;
                nr = n / g;
                dr = d / g;
                g = gcd64(r, dr);
                if (g == 0) g = 1;
                r  = r / g;
                dr = dr / g;
                if (nr == 0 || dr == 0 || r >= TOP / nr) begin
                    res.ovf = 1;
                    return res;
                end
                r = ((r * nr) & TOP) / dr;
            end else begin
                r = ((r * n) & TOP) / d;
            end
            n--;
        end
        res.coef = r & TOP;
        return res;
    endfunction

    // Queue accepted requests, compare accepted results
    always @(posedge i_clk) begin
        t_binom want;
        if (!i_rst_n) begin
            binom_q.delete();
            o_fail_count <= 0;
            o_checked    <= 0;
            o_ovf_seen   <= 0;
            o_pending    <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                binom_q.push_back(binom_of(i_set_size, i_choose_count));
            if (i_out_valid && i_out_ready) begin
                if (binom_q.size() == 0) begin
                    $display("%0t: unexpected result coef=%h ovf=%b", $time,
                             i_coefficient, i_overflowed);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = binom_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (i_overflowed) o_ovf_seen <= o_ovf_seen + 1;
                    if (want.coef !== i_coefficient || want.ovf !== i_overflowed) begin
                        $display("%0t: mismatch coef exp=%h got=%h ovf exp=%b got=%b",
                                 $time, want.coef, i_coefficient, want.ovf, i_overflowed);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= binom_q.size();
        end
    end
endmodule

FILE: tb/sv/tb_top.sv
// Top of the binomial coefficient unit testbench: clock, reset, stimulus, verdict.
`timescale 1ns / 100ps
module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [63:0] i_set_size;
    logic [63:0] i_choose_count;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_coefficient;
    logic        o_overflowed;
    int          fail_count, pending, checked, ovf_seen;
    logic        hold_req;
    int          sent;

    localparam logic [63:0] MAXW = 64'hFFFF_FFFF_FFFF_FFFF;

    binomial_coefficient_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_set_size(i_set_size), .i_choose_count(i_choose_count),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_coefficient(o_coefficient), .o_overflowed(o_overflowed)
    );

    bcu_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_set_size(i_set_size), .i_choose_count(i_choose_count),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_coefficient(o_coefficient), .i_overflowed(o_overflowed),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_checked(checked), .o_ovf_seen(ovf_seen)
    );

    // Clock
    initial i_clk = 0;
    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // Run limit
    initial begin
        #60_000_000;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: random stall pattern, plus one long hold-off on request
    initial begin
        int  hold_cnt;
        int  phase_left;
        bit  stall_mode;
        bit  hold_done;
        hold_cnt   = 0;
        phase_left = 0;
        stall_mode = 0;
        hold_done  = 0;
        i_out_ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_cnt  = 3000;
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(5, 60);
                stall_mode = 1'($urandom_range(0, 1));
            end
            phase_left--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_ready <= 0;
            end else begin
                i_out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
            end
        end
    end

    // One request, held until accepted
    task automatic send_req(input logic [63:0] n, input logic [63:0] k);
        i_in_valid     <= 1;
        i_set_size     <= n;
        i_choose_count <= k;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic [63:0] n, k;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            n = 64'($urandom_range(0, 70));
            k = 64'($urandom_range(0, 32'(n) + 32'd2));
        end else if (sel < 70) begin
            n = {$urandom, $urandom};
            k = 64'($urandom_range(0, 4));
        end else if (sel < 85) begin
            n = {$urandom, $urandom};
            k = {$urandom, $urandom};
        end else begin
            n = 64'($urandom_range(0, 40000));
            k = 64'($urandom_range(0, 20));
            if ($urandom_range(0, 1)) k = n - k;
        end
        send_req(n, k);
    endtask

    // Stimulus
    initial begin
        int burst;
        i_rst_n        = 0;
        i_in_valid     = 0;
        i_set_size     = 0;
        i_choose_count = 0;
        hold_req       = 0;
        sent           = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed corners: trivial cases, mirroring, overflow edges
        send_req(0, 0);
        send_req(0, 1);
        send_req(5, 0);
        send_req(5, 1);
        send_req(0, 5);
        send_req(7, 7);
        send_req(7, 9);
        send_req(MAXW, MAXW);
        send_req(MAXW, 0);
        send_req(MAXW, 1);
        send_req(MAXW, 2);
        send_req(MAXW, MAXW - 1);
        send_req(10, 7);
        send_req(10, 3);
        send_req(62, 31);
        send_req(66, 33);
        send_req(67, 33);
        send_req(68, 34);
        send_req(64'h1_0000_0000, 2);
        send_req(64'h8000_0000_0000_0000, 2);
        send_req(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_req(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5554);

        // Random bursts with gaps; long receiver hold-off midway, then a drain pause
        while (sent < 100) begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
                if (sent == 50) hold_req <= 1;
                send_random();
            end
            i_in_valid <= 0;
            if (sent >= 80 && sent < 90)
                while (pending != 0) @(negedge i_clk);
            else
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 0;

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("covered %0d requests: trivial, mirrored, gcd-reduced and overflow cases",
                 sent);
        $display("results checked %0d, overflow results %0d", checked, ovf_seen);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
